@@ rtl/pnm_pkg.sv @@
`default_nettype none
package pnm_pkg;

	localparam int TILE_DEF    = 64;
	localparam int MAX_DIM_DEF = 4096;

	localparam int COORD_W = 12;
	localparam int ADDR_W  = 24;
	localparam int DIM_W   = 13;
	localparam int ACC_W   = 17;
	localparam int NUMER_W = 24;
	localparam int DENOM_W = 16;

	localparam logic [ACC_W-1:0] ACC_MAX = 17'd131071;
	localparam logic [DIM_W-1:0] DIM_SAT = 13'd8191;

	localparam logic [7:0] CH_P    = 8'h50;
	localparam logic [7:0] CH_HASH = 8'h23;
	localparam logic [7:0] CH_LF   = 8'h0a;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_ONE  = 8'h31;
	localparam logic [7:0] CH_SIX  = 8'h36;

	localparam logic [1:0] KIND_PIXEL  = 2'd0;
	localparam logic [1:0] KIND_HEADER = 2'd1;
	localparam logic [1:0] KIND_ERROR  = 2'd2;
	localparam logic [1:0] KIND_DONE   = 2'd3;

	localparam logic [2:0] ERR_NONE      = 3'd0;
	localparam logic [2:0] ERR_MAGIC     = 3'd1;
	localparam logic [2:0] ERR_VERSION   = 3'd2;
	localparam logic [2:0] ERR_NUMBER    = 3'd3;
	localparam logic [2:0] ERR_NO_SPACE  = 3'd4;
	localparam logic [2:0] ERR_TRUNCATED = 3'd5;
	localparam logic [2:0] ERR_MAXVAL    = 3'd6;
	localparam logic [2:0] ERR_SIZE      = 3'd7;

	typedef struct packed {
		logic [1:0]         kind;
		logic [7:0]         red;
		logic [7:0]         green;
		logic [7:0]         blue;
		logic [COORD_W-1:0] column;
		logic [COORD_W-1:0] row;
		logic [ADDR_W-1:0]  pixel_address;
		logic [2:0]         error_code;
		logic               last_of_run;
	} res_t;

	typedef struct packed {
		logic               start;
		logic [NUMER_W-1:0] numer;
		logic [DENOM_W-1:0] denom;
	} div_req_t;

	function automatic logic is_space(input logic [7:0] b);
		return (b == 8'd32) || ((b >= 8'd9) && (b <= 8'd13));
	endfunction

	function automatic logic is_digit(input logic [7:0] b);
		return (b >= 8'd48) && (b <= 8'd57);
	endfunction

	function automatic res_t mk_res(input logic [1:0] kind, input logic [2:0] err);
		res_t r;
		r = '0;
		r.kind = kind;
		r.error_code = err;
		return r;
	endfunction

endpackage
`default_nettype wire

@@ rtl/pnm_if.sv @@
`default_nettype none
interface pnm_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       start_of_file;
	logic       end_of_file;
	modport source (output valid, in_byte, start_of_file, end_of_file, input ready);
	modport sink (input valid, in_byte, start_of_file, end_of_file, output ready);
endinterface

interface pnm_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [7:0]  red;
	logic [7:0]  green;
	logic [7:0]  blue;
	logic [11:0] column;
	logic [11:0] row;
	logic [23:0] pixel_address;
	logic [2:0]  error_code;
	logic        last_of_run;
	modport source (output valid, kind, red, green, blue, column, row, pixel_address,
		error_code, last_of_run, input ready);
	modport sink (input valid, kind, red, green, blue, column, row, pixel_address,
		error_code, last_of_run, output ready);
endinterface
`default_nettype wire

@@ rtl/pnm_div.sv @@
`default_nettype none
// restoring divider, quotient known to be below 256: one bit a cycle
module pnm_div (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire pnm_pkg::div_req_t req,
	output logic [7:0]             quot,
	output logic                   done
);
	localparam int DS_W = pnm_pkg::DENOM_W + 7;

	logic [pnm_pkg::NUMER_W-1:0] rem_q;
	logic [DS_W-1:0]             ds_q;
	logic [7:0]                  quot_q;
	logic [2:0]                  cnt_q;
	logic                        busy_q;
	logic                        done_q;
	logic                        fits;

	assign fits = rem_q >= pnm_pkg::NUMER_W'(ds_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q  <= '0;
			ds_q   <= '0;
			quot_q <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				rem_q  <= req.numer;
				ds_q   <= {req.denom, 7'd0};
				cnt_q  <= 3'd7;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				if (fits) begin
					rem_q <= rem_q - pnm_pkg::NUMER_W'(ds_q);
				end
				quot_q <= {quot_q[6:0], fits};
				ds_q   <= ds_q >> 1;
				cnt_q  <= cnt_q - 3'd1;
				if (cnt_q == 3'd0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	assign quot = quot_q;
	assign done = done_q;

`ifndef SYNTHESIS
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> !busy_q) else $error("divider restarted while busy");
	a_done_once: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> !busy_q) else $error("divider done while busy");
	a_done_end: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q) && ($past(cnt_q) == 3'd0))
		else $error("divider done out of order");
`endif
endmodule
`default_nettype wire

@@ rtl/pnm_stream_decoder.sv @@
`default_nettype none
// channel  dir  payload                                              handshake
// data     in   in_byte, start_of_file, end_of_file                  valid/ready
// result   out  kind, red, green, blue, column, row, pixel_address,  valid/ready
//               error_code, last_of_run
// a byte goes idle, parse, eof check, flush; each pixel adds channel or bit, pixel,
// return; the image-complete word its own state; a scaled sample the shared divider
// data.ready is high only while the sequencer waits for a byte
// results leave through a hold register and an output register; a full output
// stalls the sequencer, the byte in work holds
// arst_n clears the parser to wait for the magic letter; TILE must be a power of two
module pnm_stream_decoder #(
	parameter int TILE    = pnm_pkg::TILE_DEF,
	parameter int MAX_DIM = pnm_pkg::MAX_DIM_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	pnm_in_if.sink    data,
	pnm_out_if.source result
);
	localparam int LOG_T  = $clog2(TILE);
	localparam int ACR_W  = $clog2((MAX_DIM + TILE - 1) / TILE + 1);
	localparam int TY_W   = pnm_pkg::COORD_W - LOG_T;
	localparam int TILE_W = TY_W + ACR_W + 1;
	localparam int DW     = pnm_pkg::DIM_W;
	localparam int AW     = pnm_pkg::ACC_W;

	localparam logic [2:0] PH_MAGIC   = 3'd0;
	localparam logic [2:0] PH_VERSION = 3'd1;
	localparam logic [2:0] PH_WIDTH   = 3'd2;
	localparam logic [2:0] PH_HEIGHT  = 3'd3;
	localparam logic [2:0] PH_MAXVAL  = 3'd4;
	localparam logic [2:0] PH_DATA    = 3'd5;
	localparam logic [2:0] PH_DONE    = 3'd6;
	localparam logic [2:0] PH_ERROR   = 3'd7;

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_PARSE = 4'd1;
	localparam logic [3:0] S_DIV   = 4'd2;
	localparam logic [3:0] S_CHAN  = 4'd3;
	localparam logic [3:0] S_PIX   = 4'd4;
	localparam logic [3:0] S_DONE3 = 4'd5;
	localparam logic [3:0] S_RET   = 4'd6;
	localparam logic [3:0] S_PBM   = 4'd7;
	localparam logic [3:0] S_EOF   = 4'd8;
	localparam logic [3:0] S_FLUSH = 4'd9;

	localparam logic [1:0] RET_ASCII = 2'd0;
	localparam logic [1:0] RET_NONE  = 2'd1;
	localparam logic [1:0] RET_PBM   = 2'd2;
	localparam logic [1:0] RET_EOF   = 2'd3;

	logic [3:0]    state_q;
	logic [1:0]    ret_q;
	logic [2:0]    phase_q;
	logic [2:0]    ver_q;
	logic [DW-1:0] width_q;
	logic [DW-1:0] height_q;
	logic [AW-1:0] max_q;
	logic [AW-1:0] acc_q;
	logic          cmt_q;
	logic          dig_q;
	logic [11:0]   col_q;
	logic [11:0]   row_q;
	logic [1:0]    chan_q;
	logic [7:0]    part_r_q;
	logic [7:0]    part_g_q;
	logic          hold_v_q;
	logic [7:0]    hold_b_q;
	logic [ACR_W-1:0] across_q;
	logic [7:0]    b_q;
	logic          eof_q;
	logic [7:0]    sample_q;
	logic [7:0]    px_r_q;
	logic [7:0]    px_g_q;
	logic [7:0]    px_b_q;
	logic [2:0]    k_q;
	logic          rowend_q;
	pnm_pkg::div_req_t div_req_q;
	logic [7:0]    div_quot;
	logic          div_done;

	pnm_pkg::res_t pend_q;
	logic          pend_v_q;
	pnm_pkg::res_t out_q;
	logic          out_v_q;

	logic          out_free;
	logic          go;
	logic          pbm;
	logic          hdr_last;
	logic [AW+3:0] acc_mul;
	logic [AW-1:0] acc_next;
	logic [DW-1:0] acc_dim;
	logic [DW-1:0] fin_h;
	logic [AW-1:0] fin_m;
	logic [AW-1:0] sc_v;
	logic          sc_sat;
	logic [pnm_pkg::NUMER_W-1:0] sc_numer;
	logic [DW:0]   col_inc;
	logic [DW:0]   row_inc;
	logic [TILE_W-1:0] tile_idx;
	logic [pnm_pkg::ADDR_W-1:0] pix_addr;
	logic [ACR_W-1:0] fin_across;

	pnm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req_q),
		.quot   (div_quot),
		.done   (div_done)
	);

	assign out_free = !out_v_q || result.ready;
	assign go       = !(pend_v_q && !out_free);
	assign pbm      = (ver_q == 3'd1) || (ver_q == 3'd4);
	assign hdr_last = (phase_q == PH_MAXVAL) || ((phase_q == PH_HEIGHT) && pbm);

	assign acc_mul  = (AW+4)'(acc_q) * (AW+4)'(10) + (AW+4)'(b_q - pnm_pkg::CH_ZERO);
	assign acc_next = (acc_mul > (AW+4)'(pnm_pkg::ACC_MAX)) ? pnm_pkg::ACC_MAX :
		acc_mul[AW-1:0];
	assign acc_dim  = (acc_q > AW'(pnm_pkg::DIM_SAT)) ? pnm_pkg::DIM_SAT : acc_q[DW-1:0];
	assign fin_h    = (phase_q == PH_HEIGHT) ? acc_dim : height_q;
	assign fin_m    = pbm ? AW'(1) : ((phase_q == PH_MAXVAL) ? acc_q : max_q);
	assign fin_across = ACR_W'(((DW+1)'(width_q) + (DW+1)'(TILE - 1)) >> LOG_T);

	// sample to scale: a finished ascii number, a 16-bit pair or a plain byte
	always_comb begin
		if ((state_q == S_PARSE) && (ver_q >= 3'd5)) begin
			sc_v = (max_q > AW'(255)) ? AW'({hold_b_q, b_q}) : AW'(b_q);
		end else begin
			sc_v = acc_q;
		end
	end
	assign sc_sat   = (max_q == '0) || (sc_v >= max_q);
	assign sc_numer = pnm_pkg::NUMER_W'({sc_v[15:0], 8'h00}) -
		pnm_pkg::NUMER_W'(sc_v[15:0]);

	assign col_inc  = (DW+1)'(col_q) + (DW+1)'(1);
	assign row_inc  = (DW+1)'(row_q) + (DW+1)'(1);
	assign tile_idx = TILE_W'(row_q[11:LOG_T]) * TILE_W'(across_q) +
		TILE_W'(col_q[11:LOG_T]);
	assign pix_addr = pnm_pkg::ADDR_W'({tile_idx, row_q[LOG_T-1:0], col_q[LOG_T-1:0]});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			ret_q     <= RET_NONE;
			phase_q   <= PH_MAGIC;
			ver_q     <= '0;
			width_q   <= '0;
			height_q  <= '0;
			max_q     <= '0;
			acc_q     <= '0;
			cmt_q     <= 1'b0;
			dig_q     <= 1'b0;
			col_q     <= '0;
			row_q     <= '0;
			chan_q    <= '0;
			part_r_q  <= '0;
			part_g_q  <= '0;
			hold_v_q  <= 1'b0;
			hold_b_q  <= '0;
			across_q  <= '0;
			b_q       <= '0;
			eof_q     <= 1'b0;
			sample_q  <= '0;
			px_r_q    <= '0;
			px_g_q    <= '0;
			px_b_q    <= '0;
			k_q       <= '0;
			rowend_q  <= 1'b0;
			div_req_q <= '0;
			pend_q    <= '0;
			pend_v_q  <= 1'b0;
			out_q     <= '0;
			out_v_q   <= 1'b0;
		end else begin : seq
			pnm_pkg::res_t em;
			logic          em_v;
			logic          flush;
			logic [3:0]    st_n;
			logic          dv_go;
			pnm_pkg::res_t fl;
			em    = '0;
			em_v  = 1'b0;
			flush = 1'b0;
			st_n  = state_q;
			dv_go = 1'b0;
			fl    = pend_q;
			fl.last_of_run = 1'b1;

			unique case (state_q)
				S_IDLE: begin
					if (data.valid) begin
						b_q   <= data.in_byte;
						eof_q <= data.end_of_file;
						st_n  = S_PARSE;
						if (data.start_of_file) begin
							phase_q  <= PH_MAGIC;
							ver_q    <= '0;
							width_q  <= '0;
							height_q <= '0;
							max_q    <= '0;
							acc_q    <= '0;
							cmt_q    <= 1'b0;
							dig_q    <= 1'b0;
							col_q    <= '0;
							row_q    <= '0;
							chan_q   <= '0;
							part_r_q <= '0;
							part_g_q <= '0;
							hold_v_q <= 1'b0;
							hold_b_q <= '0;
						end
					end
				end
				S_PARSE: if (go) begin
					st_n = S_EOF;
					unique case (phase_q)
						PH_MAGIC: begin
							if (b_q == pnm_pkg::CH_P) begin
								phase_q <= PH_VERSION;
							end else begin
								em = pnm_pkg::mk_res(pnm_pkg::KIND_ERROR, pnm_pkg::ERR_MAGIC);
								em_v = 1'b1;
								phase_q <= PH_ERROR;
							end
						end
						PH_VERSION: begin
							if ((b_q >= pnm_pkg::CH_ONE) && (b_q <= pnm_pkg::CH_SIX)) begin
								ver_q   <= 3'(b_q - pnm_pkg::CH_ZERO);
								phase_q <= PH_WIDTH;
							end else begin
								em = pnm_pkg::mk_res(pnm_pkg::KIND_ERROR, pnm_pkg::ERR_VERSION);
								em_v = 1'b1;
								phase_q <= PH_ERROR;
							end
						end
						PH_WIDTH, PH_HEIGHT, PH_MAXVAL: begin
							if (cmt_q) begin
								if (b_q == pnm_pkg::CH_LF) begin
									cmt_q <= 1'b0;
								end
							end else if (pnm_pkg::is_digit(b_q)) begin
								acc_q <= acc_next;
								dig_q <= 1'b1;
							end else if (dig_q && hdr_last) begin
								acc_q <= '0;
								dig_q <= 1'b0;
								if (phase_q == PH_HEIGHT) begin
									height_q <= acc_dim;
								end else begin
									max_q <= acc_q;
								end
								em_v = 1'b1;
								if (!pnm_pkg::is_space(b_q)) begin
									em = pnm_pkg::mk_res(pnm_pkg::KIND_ERROR,
										pnm_pkg::ERR_NO_SPACE);
									phase_q <= PH_ERROR;
								end else if (!pbm && ((fin_m == '0) ||
										(fin_m > AW'(65535)))) begin
									em = pnm_pkg::mk_res(pnm_pkg::KIND_ERROR,
										pnm_pkg::ERR_MAXVAL);
									phase_q <= PH_ERROR;
								end else if ((width_q == '0) || (width_q > DW'(MAX_DIM)) ||
										(fin_h == '0) || (fin_h > DW'(MAX_DIM))) begin
									em = pnm_pkg::mk_res(pnm_pkg::KIND_ERROR,
										pnm_pkg::ERR_SIZE);
									phase_q <= PH_ERROR;
								end else begin
									em = pnm_pkg::mk_res(pnm_pkg::KIND_HEADER,
										pnm_pkg::ERR_NONE);
									max_q    <= fin_m;
									phase_q  <= PH_DATA;
									across_q <= fin_across;
									col_q    <= '0;
									row_q    <= '0;
									chan_q   <= '0;
									part_r_q <= '0;
									part_g_q <= '0;
									hold_v_q <= 1'b0;
									hold_b_q <= '0;
									cmt_q    <= 1'b0;
								end
							end else begin
								if (dig_q) begin
									acc_q <= '0;
									dig_q <= 1'b0;
									if (phase_q == PH_WIDTH) begin
										width_q <= acc_dim;
									end else begin
										height_q <= acc_dim;
									end
									phase_q <= phase_q + 3'd1;
								end
								if (b_q == pnm_pkg::CH_HASH) begin
									cmt_q <= 1'b1;
								end else if (!pnm_pkg::is_space(b_q)) begin
									em = pnm_pkg::mk_res(pnm_pkg::KIND_ERROR,
										pnm_pkg::ERR_NUMBER);
									em_v = 1'b1;
									phase_q <= PH_ERROR;
								end
							end
						end
						PH_DATA: begin
							if (ver_q <= 3'd3) begin
								if (pnm_pkg::is_digit(b_q)) begin
									acc_q <= acc_next;
									dig_q <= 1'b1;
								end else if (dig_q) begin
									acc_q <= '0;
									dig_q <= 1'b0;
									ret_q <= RET_ASCII;
									if (sc_sat) begin
										sample_q <= 8'hff;
										st_n     = S_CHAN;
									end else begin
										dv_go = 1'b1;
										st_n  = S_DIV;
									end
								end else if (!pnm_pkg::is_space(b_q)) begin
									em = pnm_pkg::mk_res(pnm_pkg::KIND_ERROR,
										pnm_pkg::ERR_NUMBER);
									em_v = 1'b1;
									phase_q <= PH_ERROR;
								end
							end else if (ver_q == 3'd4) begin
								k_q  <= '0;
								st_n = S_PBM;
							end else if ((max_q > AW'(255)) && !hold_v_q) begin
								hold_v_q <= 1'b1;
								hold_b_q <= b_q;
							end else begin
								hold_v_q <= 1'b0;
								ret_q    <= RET_NONE;
								if (max_q == AW'(65535)) begin
									sample_q <= hold_b_q;
									st_n     = S_CHAN;
								end else if (sc_sat) begin
									sample_q <= 8'hff;
									st_n     = S_CHAN;
								end else begin
									dv_go = 1'b1;
									st_n  = S_DIV;
								end
							end
						end
						default: begin
						end
					endcase
				end
				S_DIV: begin
					if (div_done) begin
						sample_q <= div_quot;
						st_n     = S_CHAN;
					end
				end
				S_CHAN: begin
					if ((ver_q == 3'd3) || (ver_q == 3'd6)) begin
						unique case (chan_q)
							2'd0: begin
								part_r_q <= sample_q;
								chan_q   <= 2'd1;
								st_n     = S_RET;
							end
							2'd1: begin
								part_g_q <= sample_q;
								chan_q   <= 2'd2;
								st_n     = S_RET;
							end
							default: begin
								chan_q <= 2'd0;
								px_r_q <= part_r_q;
								px_g_q <= part_g_q;
								px_b_q <= sample_q;
								st_n   = S_PIX;
							end
						endcase
					end else begin
						px_r_q <= sample_q;
						px_g_q <= sample_q;
						px_b_q <= sample_q;
						st_n   = S_PIX;
					end
				end
				S_PBM: begin
					px_r_q <= {8{b_q[3'd7 - k_q]}};
					px_g_q <= {8{b_q[3'd7 - k_q]}};
					px_b_q <= {8{b_q[3'd7 - k_q]}};
					ret_q  <= RET_PBM;
					st_n   = S_PIX;
				end
				S_PIX: if (go) begin
					em = '0;
					em.kind = pnm_pkg::KIND_PIXEL;
					em.red = px_r_q;
					em.green = px_g_q;
					em.blue = px_b_q;
					em.column = col_q;
					em.row = row_q;
					em.pixel_address = pix_addr;
					em_v = 1'b1;
					if (col_inc < (DW+1)'(width_q)) begin
						col_q    <= col_inc[11:0];
						rowend_q <= 1'b0;
						st_n     = S_RET;
					end else begin
						col_q    <= '0;
						row_q    <= row_inc[11:0];
						rowend_q <= 1'b1;
						st_n     = (row_inc >= (DW+1)'(height_q)) ? S_DONE3 : S_RET;
					end
				end
				S_DONE3: if (go) begin
					em = pnm_pkg::mk_res(pnm_pkg::KIND_DONE, pnm_pkg::ERR_NONE);
					em_v = 1'b1;
					phase_q <= PH_DONE;
					st_n    = S_RET;
				end
				S_RET: if (go) begin
					unique case (ret_q)
						RET_ASCII: begin
							st_n = S_EOF;
							if ((phase_q == PH_DATA) && !pnm_pkg::is_space(b_q)) begin
								em = pnm_pkg::mk_res(pnm_pkg::KIND_ERROR,
									pnm_pkg::ERR_NUMBER);
								em_v = 1'b1;
								phase_q <= PH_ERROR;
							end
						end
						RET_PBM: begin
							if (rowend_q || (k_q == 3'd7)) begin
								st_n = S_EOF;
							end else begin
								k_q  <= k_q + 3'd1;
								st_n = S_PBM;
							end
						end
						RET_EOF: begin
							st_n = S_FLUSH;
							if (phase_q == PH_DATA) begin
								em = pnm_pkg::mk_res(pnm_pkg::KIND_ERROR,
									pnm_pkg::ERR_TRUNCATED);
								em_v = 1'b1;
								phase_q <= PH_ERROR;
							end
						end
						default: st_n = S_EOF;
					endcase
				end
				S_EOF: if (go) begin
					st_n = S_FLUSH;
					if (eof_q) begin
						unique case (phase_q)
							PH_MAGIC: begin
								em = pnm_pkg::mk_res(pnm_pkg::KIND_ERROR, pnm_pkg::ERR_MAGIC);
								em_v = 1'b1;
								phase_q <= PH_ERROR;
							end
							PH_VERSION: begin
								em = pnm_pkg::mk_res(pnm_pkg::KIND_ERROR,
									pnm_pkg::ERR_TRUNCATED);
								em_v = 1'b1;
								phase_q <= PH_ERROR;
							end
							PH_WIDTH, PH_HEIGHT, PH_MAXVAL: begin
								em = pnm_pkg::mk_res(pnm_pkg::KIND_ERROR,
									(dig_q && hdr_last) ? pnm_pkg::ERR_NO_SPACE :
									pnm_pkg::ERR_NUMBER);
								em_v = 1'b1;
								phase_q <= PH_ERROR;
							end
							PH_DATA: begin
								if ((ver_q <= 3'd3) && dig_q) begin
									acc_q <= '0;
									dig_q <= 1'b0;
									ret_q <= RET_EOF;
									if (sc_sat) begin
										sample_q <= 8'hff;
										st_n     = S_CHAN;
									end else begin
										dv_go = 1'b1;
										st_n  = S_DIV;
									end
								end else begin
									em = pnm_pkg::mk_res(pnm_pkg::KIND_ERROR,
										pnm_pkg::ERR_TRUNCATED);
									em_v = 1'b1;
									phase_q <= PH_ERROR;
								end
							end
							default: begin
							end
						endcase
					end
				end
				S_FLUSH: if (go) begin
					flush = pend_v_q;
					st_n  = S_IDLE;
				end
				default: st_n = S_IDLE;
			endcase

			state_q   <= st_n;
			// operands are only taken by the divider while its start is high
			div_req_q <= '{start: dv_go, numer: sc_numer, denom: max_q[15:0]};

			// hold register keeps the newest word until it is known whether it ends the run
			if (em_v) begin
				if (pend_v_q) begin
					out_q   <= pend_q;
					out_v_q <= 1'b1;
				end else if (out_v_q && result.ready) begin
					out_v_q <= 1'b0;
				end
				pend_q   <= em;
				pend_v_q <= 1'b1;
			end else if (flush) begin
				out_q    <= fl;
				out_v_q  <= 1'b1;
				pend_v_q <= 1'b0;
			end else if (out_v_q && result.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	assign data.ready           = (state_q == S_IDLE);
	assign result.valid         = out_v_q;
	assign result.kind          = out_q.kind;
	assign result.red           = out_q.red;
	assign result.green         = out_q.green;
	assign result.blue          = out_q.blue;
	assign result.column        = out_q.column;
	assign result.row           = out_q.row;
	assign result.pixel_address = out_q.pixel_address;
	assign result.error_code    = out_q.error_code;
	assign result.last_of_run   = out_q.last_of_run;

`ifndef SYNTHESIS
	a_idle_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> !pend_v_q) else $error("word left pending at idle");
	a_div_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (state_q == S_DIV)) else $error("divider result unexpected");
	a_pix_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_PIX) |-> ((DW'(col_q) < width_q) && (phase_q == PH_DATA)))
		else $error("pixel outside image");
`endif
endmodule
`default_nettype wire
